[hw/rtl/wrrc_pkg.sv]
package wrrc_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_RECEIVERS_DEF = 16;
  localparam int CAP_EXPIRE_MS_DEF = 1000;

  // Field widths
  localparam int ID_W    = 32;
  localparam int RATE_W  = 32;
  localparam int LOSS_W  = 8;
  localparam int DROPS_W = 16;
  localparam int TIME_W  = 48;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;

  // Loss threshold in Q8 at which a cap applies
  localparam logic [LOSS_W-1:0] LOSS_THRESHOLD_Q8 = 8'd26;

  // Opcodes
  localparam logic OP_REPORT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // Cap reason codes
  localparam logic [1:0] REASON_NONE  = 2'd0;
  localparam logic [1:0] REASON_LOSS  = 2'd1;
  localparam logic [1:0] REASON_WORST = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_MIN_BITRATE   = 2'd0;
  localparam logic [1:0] REG_START_BITRATE = 2'd1;
  localparam logic [1:0] REG_DEFAULT_RX    = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_LAST,
    ST_FINISH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic write;
    logic scan_clr;
    logic scan_rd;
    logic load_out;
  } cmd_t;

endpackage

[hw/rtl/wrrc_ctrl.sv]
module wrrc_ctrl #(
  parameter int MAX_RECEIVERS = wrrc_pkg::MAX_RECEIVERS_DEF,
  localparam int IDX_W = (MAX_RECEIVERS > 1) ? $clog2(MAX_RECEIVERS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output wrrc_pkg::cmd_t    cmd,
  output logic [IDX_W-1:0]  rd_idx
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_RECEIVERS - 1);

  wrrc_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;

  // State, scan counter and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wrrc_pkg::ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Sequence one transaction: capture, table write, scan, result load
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      wrrc_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = wrrc_pkg::ST_WRITE;
        end
      end
      wrrc_pkg::ST_WRITE: begin
        cmd.write    = 1'b1;
        cmd.scan_clr = 1'b1;
        idx_nxt      = '0;
        state_nxt    = wrrc_pkg::ST_SCAN;
      end
      wrrc_pkg::ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = wrrc_pkg::ST_LAST;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      wrrc_pkg::ST_LAST: begin
        state_nxt = wrrc_pkg::ST_FINISH;
      end
      wrrc_pkg::ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = wrrc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wrrc_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_ready  = (state_r == wrrc_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign rd_idx    = idx_r;

  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while pending");

  // An accepted transaction moves straight to the table write
  a_accept_write: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == wrrc_pkg::ST_WRITE))
    else $error("accepted transaction did not reach table write");

  // A loaded result shows valid on the next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");

endmodule

[hw/rtl/wrrc_dp.sv]
module wrrc_dp #(
  parameter int MAX_RECEIVERS = wrrc_pkg::MAX_RECEIVERS_DEF,
  parameter int CAP_EXPIRE_MS = wrrc_pkg::CAP_EXPIRE_MS_DEF,
  localparam int IDX_W = (MAX_RECEIVERS > 1) ? $clog2(MAX_RECEIVERS) : 1,
  localparam int CNT_W = $clog2(MAX_RECEIVERS + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  wrrc_pkg::cmd_t                    cmd,
  input  logic [IDX_W-1:0]                  rd_idx,
  input  logic [wrrc_pkg::RATE_W-1:0]       min_bitrate,
  input  logic [wrrc_pkg::RATE_W-1:0]       start_bitrate,
  input  logic [wrrc_pkg::ID_W-1:0]         default_receiver,
  input  logic                              in_opcode,
  input  logic [wrrc_pkg::ID_W-1:0]         in_receiver,
  input  logic [wrrc_pkg::LOSS_W-1:0]       in_loss_fraction,
  input  logic [wrrc_pkg::DROPS_W-1:0]      in_dropped_frames,
  input  logic [wrrc_pkg::TIME_W-1:0]       in_event_time_us,
  output logic                              out_cap_active,
  output logic [wrrc_pkg::RATE_W-1:0]       out_cap_bps,
  output logic [1:0]                        out_cap_reason,
  output logic [wrrc_pkg::ID_W-1:0]         out_worst_receiver,
  output logic [wrrc_pkg::LOSS_W-1:0]       out_worst_loss,
  output logic [wrrc_pkg::DROPS_W-1:0]      out_worst_drops,
  output logic                              out_table_full
);

  localparam int DIFF_W = wrrc_pkg::TIME_W + 1;
  localparam logic signed [DIFF_W-1:0] EXPIRE_US = DIFF_W'(CAP_EXPIRE_MS * 1000);

  // Captured transaction
  logic                              op_r;
  logic [wrrc_pkg::ID_W-1:0]         id_r;
  logic [wrrc_pkg::LOSS_W-1:0]       loss_r;
  logic [wrrc_pkg::DROPS_W-1:0]      drops_r;
  logic [wrrc_pkg::TIME_W-1:0]       now_r;

  // Receiver table
  logic [MAX_RECEIVERS-1:0]          valid_r;
  logic [CNT_W-1:0]                  count_r;
  logic [wrrc_pkg::ID_W-1:0]         ent_rx_r    [MAX_RECEIVERS];
  logic                              ent_capped_r[MAX_RECEIVERS];
  logic [wrrc_pkg::RATE_W-1:0]       ent_cap_r   [MAX_RECEIVERS];
  logic [wrrc_pkg::LOSS_W-1:0]       ent_loss_r  [MAX_RECEIVERS];
  logic [wrrc_pkg::DROPS_W-1:0]      ent_drops_r [MAX_RECEIVERS];
  logic [wrrc_pkg::TIME_W-1:0]       ent_time_r  [MAX_RECEIVERS];

  // Scan read stage
  logic                              rd_vld_r;
  logic                              rd_valid_r;
  logic                              rd_capped_r;
  logic [wrrc_pkg::ID_W-1:0]         rd_rx_r;
  logic [wrrc_pkg::RATE_W-1:0]       rd_cap_r;
  logic [wrrc_pkg::LOSS_W-1:0]       rd_loss_r;
  logic [wrrc_pkg::DROPS_W-1:0]      rd_drops_r;
  logic [wrrc_pkg::TIME_W-1:0]       rd_time_r;

  // Running worst entry
  logic                              best_vld_r;
  logic [wrrc_pkg::ID_W-1:0]         best_rx_r;
  logic [wrrc_pkg::RATE_W-1:0]       best_cap_r;
  logic [wrrc_pkg::LOSS_W-1:0]       best_loss_r;
  logic [wrrc_pkg::DROPS_W-1:0]      best_drops_r;
  logic                              full_r;

  logic [MAX_RECEIVERS-1:0]          hit;
  logic                              hit_any;
  logic                              free_any;
  logic [IDX_W-1:0]                  hit_idx;
  logic [IDX_W-1:0]                  free_idx;
  logic [IDX_W-1:0]                  wr_idx;
  logic                              do_store;
  logic                              do_insert;
  logic                              new_capped;
  logic [wrrc_pkg::RATE_W-1:0]       half_rate;
  logic [wrrc_pkg::RATE_W-1:0]       new_cap;
  logic signed [DIFF_W-1:0]          age;
  logic                              in_force;
  logic                              worse;

  // Capture the transaction, substituting the default id for zero
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_opcode;
      id_r    <= (in_receiver != '0) ? in_receiver : default_receiver;
      loss_r  <= in_loss_fraction;
      drops_r <= in_dropped_frames;
      now_r   <= in_event_time_us;
    end
  end

  // Look up the receiver across all entries and find the first free slot
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int k = MAX_RECEIVERS - 1; k >= 0; k--) begin
      hit[k] = valid_r[k] && (ent_rx_r[k] == id_r);
      if (hit[k]) begin
        hit_idx = IDX_W'(k);
      end
      if (!valid_r[k]) begin
        free_idx = IDX_W'(k);
      end
    end
    hit_any  = |hit;
    free_any = !(&valid_r);
  end

  assign do_store   = (op_r == wrrc_pkg::OP_REPORT) && (hit_any || free_any);
  assign do_insert  = do_store && !hit_any;
  assign wr_idx     = hit_any ? hit_idx : free_idx;
  assign new_capped = (loss_r >= wrrc_pkg::LOSS_THRESHOLD_Q8) || (drops_r != '0);
  assign half_rate  = start_bitrate >> 1;
  assign new_cap    = !new_capped ? '0 :
                      (min_bitrate > half_rate) ? min_bitrate : half_rate;

  // Valid bits, fill count and table-full flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else if (cmd.write && do_insert) begin
      valid_r[wr_idx] <= 1'b1;
      count_r         <= count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      full_r <= (op_r == wrrc_pkg::OP_REPORT) && !hit_any && !free_any;
    end
  end

  // Overwrite the entry with the report
  always_ff @(posedge clk) begin
    if (cmd.write && do_store) begin
      ent_rx_r[wr_idx]     <= id_r;
      ent_capped_r[wr_idx] <= new_capped;
      ent_cap_r[wr_idx]    <= new_cap;
      ent_loss_r[wr_idx]   <= loss_r;
      ent_drops_r[wr_idx]  <= drops_r;
      ent_time_r[wr_idx]   <= now_r;
    end
  end

  // Read one entry per cycle during the scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      rd_valid_r  <= valid_r[rd_idx];
      rd_capped_r <= ent_capped_r[rd_idx];
      rd_rx_r     <= ent_rx_r[rd_idx];
      rd_cap_r    <= ent_cap_r[rd_idx];
      rd_loss_r   <= ent_loss_r[rd_idx];
      rd_drops_r  <= ent_drops_r[rd_idx];
      rd_time_r   <= ent_time_r[rd_idx];
    end
  end

  // Judge expiry and severity against the running worst
  assign age      = $signed({1'b0, now_r}) - $signed({1'b0, rd_time_r});
  assign in_force = rd_valid_r && rd_capped_r && (age <= EXPIRE_US);

  always_comb begin
    priority if (rd_cap_r != best_cap_r) begin
      worse = rd_cap_r < best_cap_r;
    end else if (rd_loss_r != best_loss_r) begin
      worse = rd_loss_r > best_loss_r;
    end else if (rd_drops_r != best_drops_r) begin
      worse = rd_drops_r > best_drops_r;
    end else begin
      worse = rd_rx_r < best_rx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_vld_r <= 1'b0;
    end else if (cmd.scan_clr) begin
      best_vld_r <= 1'b0;
    end else if (rd_vld_r && in_force) begin
      best_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r && in_force && (!best_vld_r || worse)) begin
      best_rx_r    <= rd_rx_r;
      best_cap_r   <= rd_cap_r;
      best_loss_r  <= rd_loss_r;
      best_drops_r <= rd_drops_r;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_cap_active     <= best_vld_r;
      out_cap_bps        <= best_vld_r ? best_cap_r : '0;
      out_worst_receiver <= best_vld_r ? best_rx_r : '0;
      out_worst_loss     <= best_vld_r ? best_loss_r : '0;
      out_worst_drops    <= best_vld_r ? best_drops_r : '0;
      out_table_full     <= full_r;
      if (!best_vld_r) begin
        out_cap_reason <= wrrc_pkg::REASON_NONE;
      end else if (count_r > CNT_W'(1)) begin
        out_cap_reason <= wrrc_pkg::REASON_WORST;
      end else begin
        out_cap_reason <= wrrc_pkg::REASON_LOSS;
      end
    end
  end

  // Fill count tracks the valid bits
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CNT_W'($countones(valid_r)))
    else $error("fill count disagrees with valid bits");

  // Each receiver id occupies at most one entry
  a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |-> $onehot0(hit))
    else $error("receiver id held by more than one entry");

  // An insert only happens while the table has room
  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.write && do_insert) |-> (count_r < CNT_W'(MAX_RECEIVERS)))
    else $error("insert into a full table");

endmodule

[hw/rtl/worst_receiver_rate_cap.sv]
// Channel  | Ports                                   | Handshake
// input    | in_opcode .. in_event_time_us           | in_valid / in_ready
// result   | out_cap_active .. out_table_full        | out_valid / out_ready
// config   | psel penable pwrite paddr pwdata prdata | APB, pready tied high
//
// After acceptance the transaction passes through the table write, then one entry
// read per cycle by the severity scan; ST_LAST judges the last entry and ST_FINISH
// loads the result. The next transaction is taken once the controller is back in
// the idle state.
// in_ready is high in the idle state only; a waiting result stalls the load.
// rst_n is synchronous and clears the table valid bits, count, controller and configuration registers.
module worst_receiver_rate_cap #(
  parameter int MAX_RECEIVERS = wrrc_pkg::MAX_RECEIVERS_DEF,
  parameter int CAP_EXPIRE_MS = wrrc_pkg::CAP_EXPIRE_MS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_opcode,
  input  logic [wrrc_pkg::ID_W-1:0]         in_receiver,
  input  logic [wrrc_pkg::LOSS_W-1:0]       in_loss_fraction,
  input  logic [wrrc_pkg::DROPS_W-1:0]      in_dropped_frames,
  input  logic [wrrc_pkg::TIME_W-1:0]       in_event_time_us,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_cap_active,
  output logic [wrrc_pkg::RATE_W-1:0]       out_cap_bps,
  output logic [1:0]                        out_cap_reason,
  output logic [wrrc_pkg::ID_W-1:0]         out_worst_receiver,
  output logic [wrrc_pkg::LOSS_W-1:0]       out_worst_loss,
  output logic [wrrc_pkg::DROPS_W-1:0]      out_worst_drops,
  output logic                              out_table_full,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wrrc_pkg::ADDR_W-1:0]       paddr,
  input  logic [wrrc_pkg::DATA_W-1:0]       pwdata,
  output logic [wrrc_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  localparam int IDX_W = (MAX_RECEIVERS > 1) ? $clog2(MAX_RECEIVERS) : 1;

  logic [wrrc_pkg::RATE_W-1:0] min_bitrate_r;
  logic [wrrc_pkg::RATE_W-1:0] start_bitrate_r;
  logic [wrrc_pkg::ID_W-1:0]   default_rx_r;
  logic [1:0]                  reg_idx;
  logic                        cfg_wr;
  wrrc_pkg::cmd_t              cmd;
  logic [IDX_W-1:0]            rd_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_bitrate_r   <= '0;
      start_bitrate_r <= '0;
      default_rx_r    <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        wrrc_pkg::REG_MIN_BITRATE:   min_bitrate_r   <= pwdata;
        wrrc_pkg::REG_START_BITRATE: start_bitrate_r <= pwdata;
        wrrc_pkg::REG_DEFAULT_RX:    default_rx_r    <= pwdata;
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (reg_idx)
      wrrc_pkg::REG_MIN_BITRATE:   prdata = min_bitrate_r;
      wrrc_pkg::REG_START_BITRATE: prdata = start_bitrate_r;
      wrrc_pkg::REG_DEFAULT_RX:    prdata = default_rx_r;
      default:                     prdata = '0;
    endcase
  end

  wrrc_ctrl #(
    .MAX_RECEIVERS (MAX_RECEIVERS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .rd_idx    (rd_idx)
  );

  wrrc_dp #(
    .MAX_RECEIVERS (MAX_RECEIVERS),
    .CAP_EXPIRE_MS (CAP_EXPIRE_MS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .rd_idx             (rd_idx),
    .min_bitrate        (min_bitrate_r),
    .start_bitrate      (start_bitrate_r),
    .default_receiver   (default_rx_r),
    .in_opcode          (in_opcode),
    .in_receiver        (in_receiver),
    .in_loss_fraction   (in_loss_fraction),
    .in_dropped_frames  (in_dropped_frames),
    .in_event_time_us   (in_event_time_us),
    .out_cap_active     (out_cap_active),
    .out_cap_bps        (out_cap_bps),
    .out_cap_reason     (out_cap_reason),
    .out_worst_receiver (out_worst_receiver),
    .out_worst_loss     (out_worst_loss),
    .out_worst_drops    (out_worst_drops),
    .out_table_full     (out_table_full)
  );

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int NRX = wrrc_pkg::MAX_RECEIVERS_DEF;
  localparam longint CAP_EXPIRE_US = longint'(wrrc_pkg::CAP_EXPIRE_MS_DEF) * 1000;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_PCT = 34;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS = 100;

  typedef struct packed {
    logic                         active;
    logic [wrrc_pkg::RATE_W-1:0]  bps;
    logic [1:0]                   reason;
    logic [wrrc_pkg::ID_W-1:0]    rx;
    logic [wrrc_pkg::LOSS_W-1:0]  loss;
    logic [wrrc_pkg::DROPS_W-1:0] drops;
    logic                         full;
  } cap_result_t;

  typedef struct packed {
    logic [3:0]                   cfg_set;
    logic                         op;
    logic [wrrc_pkg::ID_W-1:0]    rx;
    logic [wrrc_pkg::LOSS_W-1:0]  loss;
    logic [wrrc_pkg::DROPS_W-1:0] drops;
    logic [wrrc_pkg::TIME_W-1:0]  t;
    logic                         typed;
    cap_result_t                  want;
  } quality_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         in_opcode = wrrc_pkg::OP_REPORT;
  logic [wrrc_pkg::ID_W-1:0]    in_receiver = '0;
  logic [wrrc_pkg::LOSS_W-1:0]  in_loss_fraction = '0;
  logic [wrrc_pkg::DROPS_W-1:0] in_dropped_frames = '0;
  logic [wrrc_pkg::TIME_W-1:0]  in_event_time_us = '0;

  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic                         out_cap_active;
  logic [wrrc_pkg::RATE_W-1:0]  out_cap_bps;
  logic [1:0]                   out_cap_reason;
  logic [wrrc_pkg::ID_W-1:0]    out_worst_receiver;
  logic [wrrc_pkg::LOSS_W-1:0]  out_worst_loss;
  logic [wrrc_pkg::DROPS_W-1:0] out_worst_drops;
  logic                         out_table_full;

  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [wrrc_pkg::ADDR_W-1:0]  paddr = '0;
  logic [wrrc_pkg::DATA_W-1:0]  pwdata = '0;
  logic [wrrc_pkg::DATA_W-1:0]  prdata;
  logic                         pready;

  worst_receiver_rate_cap dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_receiver        (in_receiver),
    .in_loss_fraction   (in_loss_fraction),
    .in_dropped_frames  (in_dropped_frames),
    .in_event_time_us   (in_event_time_us),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_cap_active     (out_cap_active),
    .out_cap_bps        (out_cap_bps),
    .out_cap_reason     (out_cap_reason),
    .out_worst_receiver (out_worst_receiver),
    .out_worst_loss     (out_worst_loss),
    .out_worst_drops    (out_worst_drops),
    .out_table_full     (out_table_full),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #5 clk = ~clk;

  // Mirror of the receiver table and the configuration registers
  logic [wrrc_pkg::RATE_W-1:0]  cfg_min = '0;
  logic [wrrc_pkg::RATE_W-1:0]  cfg_start = '0;
  logic [wrrc_pkg::ID_W-1:0]    cfg_default_rx = '0;
  bit                           rx_valid [NRX];
  bit [wrrc_pkg::ID_W-1:0]      rx_id [NRX];
  bit                           rx_capped [NRX];
  logic [wrrc_pkg::RATE_W-1:0]  rx_cap [NRX];
  logic [wrrc_pkg::LOSS_W-1:0]  rx_loss [NRX];
  logic [wrrc_pkg::DROPS_W-1:0] rx_drops [NRX];
  logic [wrrc_pkg::TIME_W-1:0]  rx_time [NRX];
  int                           rx_count = 0;

  quality_item_t stim_q [$];
  quality_item_t directed_tab [$];
  cap_result_t   cap_expect_q [$];
  quality_item_t held;
  cap_result_t   predicted;
  cap_result_t   oldest;
  logic [wrrc_pkg::TIME_W-1:0] clock_us = 48'd3_000_000;
  bit            no_idle = 1'b0;
  int            mismatches = 0;
  int            quiet_cycles = 0;

  function automatic bit cap_in_force(int k, logic [wrrc_pkg::TIME_W-1:0] now);
    longint diff;
    if (!rx_valid[k] || !rx_capped[k]) return 1'b0;
    diff = longint'({16'h0, now}) - longint'({16'h0, rx_time[k]});
    return diff <= CAP_EXPIRE_US;
  endfunction

  // Lowest cap first, then higher loss, more drops, lower id
  function automatic bit more_severe(int a, int b);
    if (rx_cap[a] != rx_cap[b]) return rx_cap[a] < rx_cap[b];
    if (rx_loss[a] != rx_loss[b]) return rx_loss[a] > rx_loss[b];
    if (rx_drops[a] != rx_drops[b]) return rx_drops[a] > rx_drops[b];
    return rx_id[a] < rx_id[b];
  endfunction

  // Store a report in the mirror table, then pick the worst receiver in force
  function automatic cap_result_t predict_cap(quality_item_t it);
    cap_result_t r;
    logic [wrrc_pkg::ID_W-1:0] id;
    logic [wrrc_pkg::RATE_W-1:0] half;
    int slot;
    int free_slot;
    int sel;
    r = '0;
    if (it.op == wrrc_pkg::OP_REPORT) begin
      id = (it.rx != '0) ? it.rx : cfg_default_rx;
      slot = -1;
      free_slot = -1;
      for (int k = 0; k < NRX; k++) begin
        if (rx_valid[k] && rx_id[k] == id) begin
          slot = k;
          break;
        end
        if (!rx_valid[k] && free_slot < 0) free_slot = k;
      end
      if (slot < 0 && free_slot >= 0) begin
        slot = free_slot;
        rx_valid[slot] = 1'b1;
        rx_count++;
      end
      if (slot < 0) begin
        r.full = 1'b1;
      end else begin
        rx_id[slot] = id;
        rx_loss[slot] = it.loss;
        rx_drops[slot] = it.drops;
        rx_time[slot] = it.t;
        rx_capped[slot] = (it.loss >= wrrc_pkg::LOSS_THRESHOLD_Q8) || (it.drops != '0);
        half = cfg_start >> 1;
        rx_cap[slot] = rx_capped[slot] ? ((cfg_min > half) ? cfg_min : half) : '0;
      end
    end
    sel = -1;
    for (int k = 0; k < NRX; k++) begin
      if (cap_in_force(k, it.t) && (sel < 0 || more_severe(k, sel))) sel = k;
    end
    if (sel >= 0) begin
      r.active = 1'b1;
      r.bps = rx_cap[sel];
      r.reason = (rx_count > 1) ? wrrc_pkg::REASON_WORST : wrrc_pkg::REASON_LOSS;
      r.rx = rx_id[sel];
      r.loss = rx_loss[sel];
      r.drops = rx_drops[sel];
    end
    return r;
  endfunction

  // Random transaction: mostly ids already in the table, with a running clock
  function automatic quality_item_t random_item();
    quality_item_t it;
    int pick;
    int k;
    it = '0;
    it.op = ($urandom_range(0, 99) < 30) ? wrrc_pkg::OP_QUERY : wrrc_pkg::OP_REPORT;
    pick = $urandom_range(0, 99);
    k = $urandom_range(0, NRX - 1);
    if (pick < 10) it.rx = '0;
    else if (pick < 25 || !rx_valid[k]) it.rx = $urandom;
    else it.rx = rx_id[k];
    pick = $urandom_range(0, 99);
    if (pick < 50) it.loss = 8'($urandom_range(20, 32));
    else if (pick < 70) it.loss = 8'd30;
    else it.loss = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 50) it.drops = '0;
    else if (pick < 80) it.drops = 16'($urandom_range(1, 3));
    else it.drops = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      clock_us = clock_us + 48'($urandom_range(0, 300000));
      it.t = clock_us;
    end else if (pick < 80) begin
      clock_us = clock_us + 48'($urandom_range(900000, 1100000));
      it.t = clock_us;
    end else if (pick < 90) begin
      it.t = clock_us - 48'($urandom_range(0, 2000000));
    end else begin
      it.t = {16'($urandom), 32'($urandom)};
    end
    return it;
  endfunction

  function automatic quality_item_t make_row(input int set, input logic op,
                                             input logic [wrrc_pkg::ID_W-1:0] rx,
                                             input logic [wrrc_pkg::LOSS_W-1:0] loss,
                                             input logic [wrrc_pkg::DROPS_W-1:0] drops,
                                             input logic [wrrc_pkg::TIME_W-1:0] t);
    quality_item_t it;
    it = '0;
    it.cfg_set = 4'(set);
    it.op = op;
    it.rx = rx;
    it.loss = loss;
    it.drops = drops;
    it.t = t;
    return it;
  endfunction

  task automatic add_row(input int set, input logic op, input logic [wrrc_pkg::ID_W-1:0] rx,
                         input logic [wrrc_pkg::LOSS_W-1:0] loss,
                         input logic [wrrc_pkg::DROPS_W-1:0] drops,
                         input logic [wrrc_pkg::TIME_W-1:0] t);
    directed_tab.insert(directed_tab.size(), make_row(set, op, rx, loss, drops, t));
  endtask

  // Row whose result is plain from the table contents
  task automatic add_typed(input int set, input logic op, input logic [wrrc_pkg::ID_W-1:0] rx,
                           input logic [wrrc_pkg::LOSS_W-1:0] loss,
                           input logic [wrrc_pkg::DROPS_W-1:0] drops,
                           input logic [wrrc_pkg::TIME_W-1:0] t, input cap_result_t want);
    quality_item_t it;
    it = make_row(set, op, rx, loss, drops, t);
    it.typed = 1'b1;
    it.want = want;
    directed_tab.insert(directed_tab.size(), it);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [wrrc_pkg::DATA_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      wrrc_pkg::REG_MIN_BITRATE:   cfg_min = val;
      wrrc_pkg::REG_START_BITRATE: cfg_start = val;
      wrrc_pkg::REG_DEFAULT_RX:    cfg_default_rx = val;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int n);
    logic [wrrc_pkg::DATA_W-1:0] m;
    logic [wrrc_pkg::DATA_W-1:0] s;
    logic [wrrc_pkg::DATA_W-1:0] d;
    case (n)
      1: begin m = 32'd1000; s = '1; d = '1; end
      2: begin m = '1; s = '0; d = '0; end
      3: begin m = $urandom; s = $urandom; d = rx_id[$urandom_range(0, NRX - 1)]; end
      4: begin m = '0; s = '1; d = $urandom; end
      5: begin m = '1; s = '1; d = '0; end
      6: begin
        m = $urandom_range(0, 1000);
        s = $urandom_range(0, 3000);
        d = rx_id[$urandom_range(0, NRX - 1)];
      end
      7: begin m = $urandom; s = $urandom; d = $urandom; end
      default: begin m = '0; s = '0; d = '0; end
    endcase
    write_reg(wrrc_pkg::REG_MIN_BITRATE, m);
    write_reg(wrrc_pkg::REG_START_BITRATE, s);
    write_reg(wrrc_pkg::REG_DEFAULT_RX, d);
  endtask

  // Hold until every transaction is in and every result is out
  task automatic wait_drain();
    while (stim_q.size() != 0 || in_valid || cap_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s expected %0h got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Input side: predict on acceptance, then present the next transaction or a gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted = predict_cap(held);
        cap_expect_q.insert(cap_expect_q.size(), held.typed ? held.want : predicted);
      end
      if (!in_valid || in_ready) begin
        if (stim_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
          held = stim_q.pop_front();
          in_valid <= 1'b1;
          in_opcode <= held.op;
          in_receiver <= held.rx;
          in_loss_fraction <= held.loss;
          in_dropped_frames <= held.drops;
          in_event_time_us <= held.t;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side: random back-pressure
  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Compare each result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (cap_expect_q.size() == 0) begin
        $error("result with no transaction pending");
        mismatches++;
      end else begin
        oldest = cap_expect_q.pop_front();
        check_field("cap_active", oldest.active, out_cap_active);
        check_field("cap_bps", oldest.bps, out_cap_bps);
        check_field("cap_reason", oldest.reason, out_cap_reason);
        check_field("worst_receiver", oldest.rx, out_worst_receiver);
        check_field("worst_loss", oldest.loss, out_worst_loss);
        check_field("worst_drops", oldest.drops, out_worst_drops);
        check_field("table_full", oldest.full, out_table_full);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int cur_set;
    cur_set = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: empty table, then default id zero stored under zero
    add_typed(0, wrrc_pkg::OP_QUERY, '1, '1, '1, '0, '0);
    add_typed(0, wrrc_pkg::OP_REPORT, '0, 8'd25, '0, '0, '0);
    add_typed(0, wrrc_pkg::OP_REPORT, '0, 8'd26, '0, 48'd100,
              '{1'b1, 32'd0, wrrc_pkg::REASON_LOSS, 32'd0, 8'd26, 16'd0, 1'b0});
    add_typed(0, wrrc_pkg::OP_REPORT, 32'd7, 8'd0, 16'd1, 48'd200,
              '{1'b1, 32'd0, wrrc_pkg::REASON_WORST, 32'd0, 8'd26, 16'd0, 1'b0});
    // Half-rate cap, default id all ones, expiry edges and early query
    add_row(1, wrrc_pkg::OP_REPORT, '0, 8'd0, 16'd1, 48'd1000);
    add_row(1, wrrc_pkg::OP_REPORT, 32'd5, '1, '1, 48'd2000);
    add_row(1, wrrc_pkg::OP_QUERY, '0, '0, '0, 48'd1_000_100);
    add_row(1, wrrc_pkg::OP_QUERY, '0, '0, '0, 48'd1_000_101);
    add_row(1, wrrc_pkg::OP_QUERY, '0, '0, '0, 48'd1_001_000);
    add_row(1, wrrc_pkg::OP_QUERY, '0, '0, '0, '0);
    add_typed(1, wrrc_pkg::OP_QUERY, '0, '0, '0, '1, '0);
    add_row(1, wrrc_pkg::OP_REPORT, 32'd7, 8'd0, 16'd0, 48'd1500);
    // All-ones cap; fill the table, overflow it, then update an existing id
    for (int k = 0; k < 12; k++) begin
      add_row(2, wrrc_pkg::OP_REPORT, 32'(100 + k), 8'(26 + k), '0, 48'(3000 + k));
    end
    add_row(2, wrrc_pkg::OP_REPORT, 32'h55AA_55AA, '1, '1, 48'd4000);
    add_row(2, wrrc_pkg::OP_REPORT, '0, 8'd200, '0, 48'd4100);

    // Walk the directed table, reconfiguring between settings
    foreach (directed_tab[i]) begin
      if (directed_tab[i].cfg_set != cur_set) begin
        wait_drain();
        cur_set = directed_tab[i].cfg_set;
        apply_setting(cur_set);
      end
      stim_q.insert(stim_q.size(), directed_tab[i]);
    end

    // Random phases, one of them with no idling on either side
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drain();
      apply_setting(3 + p);
      no_idle = (p == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        stim_q.insert(stim_q.size(), random_item());
      end
    end
    wait_drain();
    no_idle = 1'b0;

    if (mismatches == 0 && cap_expect_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/wrrc_pkg.sv
hw/rtl/wrrc_ctrl.sv
hw/rtl/wrrc_dp.sv
hw/rtl/worst_receiver_rate_cap.sv
bench/tb.sv
